[hdl/pwmt_pkg.sv]
// pwmt_pkg: shared types, constants and register map helpers for the pwm timer
// no dependencies

package pwmt_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int DATA_WIDTH  = 32;
  localparam int CTL_WIDTH   = 9;

  // control bit positions
  localparam int CTL_EN0_BIT      = 0;
  localparam int CTL_CONT_BIT     = 1;
  localparam int CTL_OUT_EN_BIT   = 3;
  localparam int CTL_DUTY_POS_BIT = 3;
  localparam int CTL_INACT_POS_BIT = 4;
  localparam int CTL_LOCK_BIT     = 6;

  typedef enum logic [1:0] {
    VAR_OLD     = 2'd0,
    VAR_NEWER   = 2'd1,
    VAR_DISPLAY = 2'd2,
    VAR_LOCK    = 2'd3
  } variant_t;

  localparam variant_t VARIANT_RESET = VAR_NEWER;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_UNUSED = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    REG_CNT  = 2'd0,
    REG_PER  = 2'd1,
    REG_DUTY = 2'd2,
    REG_CTL  = 2'd3
  } reg_kind_t;

  typedef struct packed {
    logic [1:0]            command;
    logic [1:0]            reg_index;
    logic [DATA_WIDTH-1:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_data;
    logic                  pwm_level;
    logic                  period_wrap;
  } out_word_t;

  // which register sits at a word offset for a given layout
  function automatic reg_kind_t reg_at(variant_t v, logic [1:0] idx);
    reg_kind_t r;
    r = REG_CNT;
    case (v)
      VAR_OLD: begin
        case (idx)
          2'd0:    r = REG_CNT;
          2'd1:    r = REG_DUTY;
          2'd2:    r = REG_PER;
          default: r = REG_CTL;
        endcase
      end
      VAR_DISPLAY: begin
        case (idx)
          2'd0:    r = REG_CTL;
          2'd1:    r = REG_PER;
          2'd2:    r = REG_DUTY;
          default: r = REG_CNT;
        endcase
      end
      default: begin
        case (idx)
          2'd0:    r = REG_CNT;
          2'd1:    r = REG_PER;
          2'd2:    r = REG_DUTY;
          default: r = REG_CTL;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

[hdl/pwm_timer_with_lock.sv]
// pwm_timer_with_lock: left-aligned pwm timer with shadow registers and lock
// depends on pwmt_pkg

// Each accepted input word is a tick, a register read or a register write, and
// produces exactly one output word carrying read data, the pin level after the
// step and a wrap flag. All state updates happen in a single pass at the edge
// where the word is accepted, so one word is taken every clock cycle while the
// skid register is empty; the rate is set by the single register stage for the
// state plus a two-entry output buffer (output register and skid register),
// which keeps in_ready high while one finished word waits for out_ready. Each
// result is registered. The variant register (cfg_wr_en / cfg_wr_data) selects
// the register layout, the prescale-by-2 and fixed polarity of the old style and
// the lock bit of the lock variant; it takes effect at once. Period and duty are
// shadowed and become live at a counter wrap, or on any tick while disabled,
// unless the lock bit holds them. The counter is read-only.

module pwm_timer_with_lock
  import pwmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  // state registers
  variant_t               variant;
  logic [COUNT_WIDTH-1:0] period_shadow, period_shadow_next;
  logic [COUNT_WIDTH-1:0] duty_shadow, duty_shadow_next;
  logic [CTL_WIDTH-1:0]   control_bits, control_bits_next;
  logic [COUNT_WIDTH-1:0] count_value, count_value_next;
  logic [COUNT_WIDTH-1:0] period_live, period_live_next;
  logic [COUNT_WIDTH-1:0] duty_live, duty_live_next;
  logic [1:0]             polarity_live, polarity_live_next;
  logic                   prescale_phase, prescale_phase_next;

  // output buffer
  out_word_t skid_word;
  logic      skid_valid;
  out_word_t result;

  logic       in_fire;
  logic       enabled, locked, advance, do_load, wrap_hit;
  logic       enabled_next, duty_lvl, inact_lvl;
  logic [COUNT_WIDTH:0] count_inc;
  reg_kind_t  kind;
  command_t   cmd;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign cmd      = command_t'(in_word.command);
  assign kind     = reg_at(variant, in_word.reg_index);

  // enable and lock come from the current control bits
  always_comb begin
    if (variant == VAR_OLD) begin
      enabled = control_bits[CTL_EN0_BIT] && control_bits[CTL_OUT_EN_BIT];
    end else begin
      enabled = control_bits[CTL_EN0_BIT] && control_bits[CTL_CONT_BIT];
    end
    locked = (variant == VAR_LOCK) && control_bits[CTL_LOCK_BIT];
  end

  // one pass over the accepted word
  always_comb begin
    period_shadow_next  = period_shadow;
    duty_shadow_next    = duty_shadow;
    control_bits_next   = control_bits;
    count_value_next    = count_value;
    period_live_next    = period_live;
    duty_live_next      = duty_live;
    polarity_live_next  = polarity_live;
    prescale_phase_next = prescale_phase;
    result.read_data    = '0;
    wrap_hit            = 1'b0;
    do_load             = 1'b0;
    advance             = 1'b0;
    // one extra bit so count + 1 never overflows the compare
    count_inc           = {1'b0, count_value} + {{COUNT_WIDTH{1'b0}}, 1'b1};

    case (cmd)
      CMD_TICK: begin
        if (!enabled) begin
          count_value_next    = '0;
          prescale_phase_next = 1'b0;
          do_load             = 1'b1;
        end else begin
          advance = 1'b1;
          if (variant == VAR_OLD) begin
            advance             = prescale_phase;
            prescale_phase_next = !prescale_phase;
          end
          if (advance) begin
            if (count_inc >= {1'b0, period_live}) begin
              count_value_next = '0;
              wrap_hit         = 1'b1;
              do_load          = 1'b1;
            end else begin
              count_value_next = count_inc[COUNT_WIDTH-1:0];
            end
          end
        end
      end
      CMD_READ: begin
        case (kind)
          REG_PER:  result.read_data = DATA_WIDTH'(period_shadow);
          REG_DUTY: result.read_data = DATA_WIDTH'(duty_shadow);
          REG_CTL:  result.read_data = DATA_WIDTH'(control_bits);
          default:  result.read_data = DATA_WIDTH'(count_value);
        endcase
      end
      CMD_WRITE: begin
        case (kind)
          REG_PER:  period_shadow_next = in_word.write_data[COUNT_WIDTH-1:0];
          REG_DUTY: duty_shadow_next   = in_word.write_data[COUNT_WIDTH-1:0];
          REG_CTL:  control_bits_next  = in_word.write_data[CTL_WIDTH-1:0];
          default:  ;  // counter is read-only
        endcase
      end
      default: ;  // unused command does nothing
    endcase

    // shadow to live transfer, held off by the lock
    if (do_load && !locked) begin
      period_live_next   = period_shadow;
      duty_live_next     = duty_shadow;
      polarity_live_next = {control_bits[CTL_INACT_POS_BIT], control_bits[CTL_DUTY_POS_BIT]};
    end

    // pin level after the step, from the updated state
    if (variant == VAR_OLD) begin
      duty_lvl     = 1'b1;
      inact_lvl    = 1'b0;
      enabled_next = control_bits_next[CTL_EN0_BIT] && control_bits_next[CTL_OUT_EN_BIT];
    end else begin
      duty_lvl     = polarity_live_next[0];
      inact_lvl    = polarity_live_next[1];
      enabled_next = control_bits_next[CTL_EN0_BIT] && control_bits_next[CTL_CONT_BIT];
    end
    if (!enabled_next) begin
      result.pwm_level = inact_lvl;
    end else if (count_value_next < duty_live_next) begin
      result.pwm_level = duty_lvl;
    end else begin
      result.pwm_level = !duty_lvl;
    end
    result.period_wrap = wrap_hit;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      variant        <= VARIANT_RESET;
      period_shadow  <= '0;
      duty_shadow    <= '0;
      control_bits   <= '0;
      count_value    <= '0;
      period_live    <= '0;
      duty_live      <= '0;
      polarity_live  <= '0;
      prescale_phase <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        variant <= variant_t'(cfg_wr_data);
      end
      if (in_fire) begin
        period_shadow  <= period_shadow_next;
        duty_shadow    <= duty_shadow_next;
        control_bits   <= control_bits_next;
        count_value    <= count_value_next;
        period_live    <= period_live_next;
        duty_live      <= duty_live_next;
        polarity_live  <= polarity_live_next;
        prescale_phase <= prescale_phase_next;
      end
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        // no word accepted while the skid holds one
        if (out_ready) begin
          skid_valid <= 1'b0;
        end
      end else if (in_fire) begin
        if (out_valid && !out_ready) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_word <= skid_word;
      end
    end else if (in_fire) begin
      if (out_valid && !out_ready) begin
        skid_word <= result;
      end else begin
        out_word <= result;
      end
    end
  end

endmodule

[bench/tb_pwm_timer_with_lock.sv]
`timescale 1ns / 1ps
// tb_pwm_timer_with_lock: self-checking bench for the pwm timer with shadow registers and lock
// depends on pwmt_pkg and pwm_timer_with_lock; a local timer model predicts every output word

module tb_pwm_timer_with_lock;
  import pwmt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SEG_WORDS   = 250;

  logic      clk;
  logic      rst;
  logic      cfg_wr_en;
  logic [1:0] cfg_wr_data;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  pwm_timer_with_lock dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

  // 8 ns clock, starts low
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // timer model: own copy of the variant, shadows, live values and counter
  // ---------------------------------------------------------------------------
  variant_t               tm_variant  = VARIANT_RESET;
  logic [COUNT_WIDTH-1:0] tm_per_sh   = '0;
  logic [COUNT_WIDTH-1:0] tm_duty_sh  = '0;
  logic [CTL_WIDTH-1:0]   tm_ctl      = '0;
  logic [COUNT_WIDTH-1:0] tm_count    = '0;
  logic [COUNT_WIDTH-1:0] tm_per_live = '0;
  logic [COUNT_WIDTH-1:0] tm_duty_live = '0;
  logic [1:0]             tm_pol      = '0;   // bit 0 duty level, bit 1 inactive level
  logic                   tm_phase    = 1'b0; // prescale-by-2 phase of the old style

  // register kind at a word offset; newer and lock layouts map offsets one to one
  function automatic reg_kind_t offset_kind(variant_t v, logic [1:0] off);
    reg_kind_t k;
    k = reg_kind_t'(off);
    if (v == VAR_OLD) begin
      if (off == 2'd1) k = REG_DUTY;
      else if (off == 2'd2) k = REG_PER;
    end else if (v == VAR_DISPLAY) begin
      if (off == 2'd0) k = REG_CTL;
      else if (off == 2'd3) k = REG_CNT;
    end
    return k;
  endfunction

  // inverse lookup, used by the stimulus to address a register by kind
  function automatic logic [1:0] offset_of(variant_t v, reg_kind_t k);
    logic [1:0] off;
    off = 2'd0;
    for (int i = 0; i < 4; i++)
      if (offset_kind(v, 2'(i)) == k) off = 2'(i);
    return off;
  endfunction

  // control bits that must all be set for the counter to run
  function automatic logic [CTL_WIDTH-1:0] run_mask(variant_t v);
    logic [CTL_WIDTH-1:0] m;
    m = '0;
    m[CTL_EN0_BIT] = 1'b1;
    if (v == VAR_OLD) m[CTL_OUT_EN_BIT] = 1'b1;
    else m[CTL_CONT_BIT] = 1'b1;
    return m;
  endfunction

  // shadows become live, unless the lock variant holds them
  function automatic void reload_live();
    if (tm_variant == VAR_LOCK && tm_ctl[CTL_LOCK_BIT]) return;
    tm_per_live  = tm_per_sh;
    tm_duty_live = tm_duty_sh;
    tm_pol       = {tm_ctl[CTL_INACT_POS_BIT], tm_ctl[CTL_DUTY_POS_BIT]};
  endfunction

  // applies one input word to the model and returns the output word it gives
  function automatic out_word_t timer_step(in_word_t w);
    out_word_t            r;
    logic [COUNT_WIDTH:0] nxt;
    logic                 running;
    logic                 advance;
    logic                 duty_lvl;
    logic                 idle_lvl;
    r = '0;
    running = (tm_ctl & run_mask(tm_variant)) == run_mask(tm_variant);
    case (command_t'(w.command))
      CMD_TICK: begin
        if (!running) begin
          // disabled: counter parked at zero, live values track the shadows unless locked
          tm_count = '0;
          tm_phase = 1'b0;
          reload_live();
        end else begin
          advance = 1'b1;
          if (tm_variant == VAR_OLD) begin
            advance  = tm_phase;
            tm_phase = !tm_phase;
          end
          if (advance) begin
            nxt = {1'b0, tm_count} + 1'b1;
            // period zero or one wraps on every advance
            if (nxt >= {1'b0, tm_per_live}) begin
              tm_count      = '0;
              r.period_wrap = 1'b1;
              reload_live();
            end else begin
              tm_count = nxt[COUNT_WIDTH-1:0];
            end
          end
        end
      end
      CMD_READ: begin
        case (offset_kind(tm_variant, w.reg_index))
          REG_PER:  r.read_data = tm_per_sh;
          REG_DUTY: r.read_data = tm_duty_sh;
          REG_CTL:  r.read_data = DATA_WIDTH'(tm_ctl);
          default:  r.read_data = tm_count;
        endcase
      end
      CMD_WRITE: begin
        case (offset_kind(tm_variant, w.reg_index))
          REG_PER:  tm_per_sh  = w.write_data;
          REG_DUTY: tm_duty_sh = w.write_data;
          REG_CTL:  tm_ctl     = w.write_data[CTL_WIDTH-1:0];
          default:  ; // counter is read-only
        endcase
      end
      default: ; // unused code does nothing
    endcase
    // pin level after the step, with the control as it now stands
    running = (tm_ctl & run_mask(tm_variant)) == run_mask(tm_variant);
    if (tm_variant == VAR_OLD) begin
      // old style polarity is fixed
      duty_lvl = 1'b1;
      idle_lvl = 1'b0;
    end else begin
      duty_lvl = tm_pol[0];
      idle_lvl = tm_pol[1];
    end
    if (!running) r.pwm_level = idle_lvl;
    else r.pwm_level = (tm_count < tm_duty_live) ? duty_lvl : !duty_lvl;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // bookkeeping
  // ---------------------------------------------------------------------------
  in_word_t  pend_q[$];     // words waiting for the driver
  out_word_t expect_q[$];   // predicted output words, oldest first
  int        words_queued = 0;
  int        words_taken  = 0;
  logic      word_taken   = 1'b0; // current input word went in at the last rising edge
  int        send_idle;     // percent of cycles the sender holds back
  int        recv_idle;     // percent of cycles the receiver stalls
  variant_t  cur_variant  = VARIANT_RESET; // variant seen by the stimulus generator
  int        errors       = 0;
  int        cycles       = 0;
  int        cmd_seen[4]  = '{default: 0};
  int        wraps_seen   = 0;
  int        results_seen = 0;

  function automatic void check_field(string name, logic [DATA_WIDTH-1:0] exp_v,
                                      logic [DATA_WIDTH-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // monitor and predictor: everything here is sampled at the rising edge
  always @(posedge clk) begin
    out_word_t e;
    if (!rst) begin
      if (cfg_wr_en) tm_variant = variant_t'(cfg_wr_data);
      // check before predicting: a result never appears at the edge that accepts its word
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_word.period_wrap) wraps_seen++;
        if (expect_q.size() == 0) begin
          $display("%0t: unexpected output word, expected none, got %h", $time, out_word);
          errors++;
        end else begin
          e = expect_q.pop_front();
          check_field("read_data", e.read_data, out_word.read_data);
          check_field("pwm_level", DATA_WIDTH'(e.pwm_level), DATA_WIDTH'(out_word.pwm_level));
          check_field("period_wrap", DATA_WIDTH'(e.period_wrap),
                      DATA_WIDTH'(out_word.period_wrap));
        end
      end
      if (in_valid && in_ready) begin
        expect_q.push_back(timer_step(in_word));
        cmd_seen[in_word.command]++;
        words_taken++;
        word_taken = 1'b1;
      end
    end
  end

  // driver: new word at the falling edge once the previous one went in
  always @(negedge clk) begin
    if (!in_valid || word_taken) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_word  <= pend_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    word_taken = 1'b0;
  end

  // receiver stalls at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("pwm_timer_with_lock verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_item(command_t c, logic [1:0] off, logic [DATA_WIDTH-1:0] d);
    in_word_t w;
    w.command    = c;
    w.reg_index  = off;
    w.write_data = d;
    pend_q.push_back(w);
    words_queued++;
  endtask

  // access a register by kind under the current layout
  task automatic push_reg(reg_kind_t k, command_t c, logic [DATA_WIDTH-1:0] d);
    push_item(c, offset_of(cur_variant, k), d);
  endtask

  // holds the sender until every word has gone in and every result has come back
  task automatic wait_idle();
    while (words_taken != words_queued || expect_q.size() != 0) @(negedge clk);
  endtask

  // variant write while the block is idle
  task automatic set_variant(variant_t v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cur_variant = v;
  endtask

  // mostly program-then-run sequences with random content, some noise
  task automatic random_segment(int n);
    int                    start;
    int                    runs;
    int                    r;
    logic [DATA_WIDTH-1:0] per;
    logic [DATA_WIDTH-1:0] duty;
    logic [CTL_WIDTH-1:0]  ctl;
    start = words_queued;
    while (words_queued - start < n) begin
      if ($urandom_range(99) < 12) begin
        push_item(command_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom);
      end else begin
        per  = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 12);
        duty = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 14);
        ctl  = 9'($urandom_range(0, 511));
        if ($urandom_range(9) < 8) ctl |= run_mask(cur_variant);
        if (cur_variant == VAR_LOCK && $urandom_range(2) != 0) ctl[CTL_LOCK_BIT] = 1'b0;
        push_reg(REG_PER, CMD_WRITE, per);
        push_reg(REG_DUTY, CMD_WRITE, duty);
        // sometimes park the counter so the new shadows load at once
        if ($urandom_range(2) == 0) begin
          push_reg(REG_CTL, CMD_WRITE, $urandom & ~32'h1ff);
          push_item(CMD_TICK, 2'($urandom_range(0, 3)), $urandom);
        end
        push_reg(REG_CTL, CMD_WRITE, {$urandom} & ~32'h1ff | DATA_WIDTH'(ctl));
        runs = $urandom_range(4, 40);
        for (int i = 0; i < runs; i++) begin
          r = $urandom_range(99);
          if (r < 85) push_item(CMD_TICK, 2'($urandom_range(0, 3)), $urandom);
          else if (r < 95) push_item(CMD_READ, 2'($urandom_range(0, 3)), $urandom);
          else push_item(CMD_WRITE, 2'($urandom_range(0, 3)), $urandom);
        end
      end
    end
  endtask

  variant_t seg_variant[6] = '{VAR_OLD, VAR_LOCK, VAR_DISPLAY, VAR_NEWER, VAR_LOCK, VAR_OLD};

  initial begin
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_word     = '0;
    out_ready   = 1'b0;
    send_idle   = 8;
    recv_idle   = 74;
    // reset held while the clock runs, released at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, reset variant (newer layout)
    push_item(CMD_TICK, 2'd0, '0);                 // disabled tick loads zero live values
    push_item(CMD_UNUSED, 2'd3, '1);               // unused code
    push_reg(REG_PER, CMD_WRITE, '1);
    push_reg(REG_PER, CMD_READ, '0);
    push_reg(REG_DUTY, CMD_WRITE, '1);
    push_reg(REG_DUTY, CMD_READ, '1);
    push_reg(REG_CTL, CMD_WRITE, '1);              // low 9 bits kept, lock only stored here
    push_reg(REG_CTL, CMD_READ, '0);
    push_reg(REG_CNT, CMD_WRITE, '1);              // counter is read-only
    push_reg(REG_CNT, CMD_READ, '0);
    push_item(CMD_TICK, 2'd1, '1);                 // live period zero: wraps, loads full
    push_item(CMD_TICK, 2'd2, '0);
    push_reg(REG_CNT, CMD_READ, '0);
    push_reg(REG_PER, CMD_WRITE, 32'd1);
    push_reg(REG_DUTY, CMD_WRITE, '0);
    push_reg(REG_CTL, CMD_WRITE, '0);
    push_item(CMD_TICK, 2'd3, '0);                 // disabled: period one goes live
    push_reg(REG_CTL, CMD_WRITE,
             (1 << CTL_EN0_BIT) | (1 << CTL_CONT_BIT) | (1 << CTL_INACT_POS_BIT));
    push_item(CMD_TICK, 2'd0, '0);                 // period one wraps every tick
    push_item(CMD_TICK, 2'd0, '0);
    push_reg(REG_CTL, CMD_READ, '0);
    wait_idle();

    // random segments, each under its own variant; the idle waits between them
    // also hold the sender until every result is back
    for (int s = 0; s < 6; s++) begin
      if (s == 2) begin
        send_idle = 74;
        recv_idle = 8;
      end else if (s == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      set_variant(seg_variant[s]);
      random_segment(SEG_WORDS);
      wait_idle();
    end
    repeat (4) @(negedge clk);

    $display("run covered %0d ticks, %0d reads, %0d writes, %0d unused words, %0d wraps",
             cmd_seen[CMD_TICK], cmd_seen[CMD_READ], cmd_seen[CMD_WRITE],
             cmd_seen[CMD_UNUSED], wraps_seen);
    $display("all four register layouts driven; %0d results checked, %0d mismatches",
             results_seen, errors);
    if (errors == 0 && expect_q.size() == 0) begin
      $display("pwm_timer_with_lock verification clean");
    end else begin
      $display("pwm_timer_with_lock verification failed");
    end
    $finish;
  end

endmodule
